// ===== design/semi_lagrangian_grid_advect_assert.svh =====
// assertion macros for the grid advection block
// used by modules that check their own control logic
`ifndef SEMI_LAGRANGIAN_GRID_ADVECT_ASSERT_SVH
`define SEMI_LAGRANGIAN_GRID_ADVECT_ASSERT_SVH
`define SLA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SLA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== design/sla_pkg.sv =====
// package for the grid advection block: sizes, codes and helpers
// no dependencies
package sla_pkg;
   localparam int GRID_W = 62;
   localparam int GRID_H = 62;
   localparam int FRAC_BITS = 16;
   localparam int PAD_W = GRID_W + 2;
   localparam int PAD_H = GRID_H + 2;
   localparam int STORE_N = PAD_W * PAD_H;
   localparam int ADDR_W = $clog2(STORE_N);
   localparam int VAL_W = 24;
   localparam int POS_W = 40;

   typedef enum logic [1:0] {
      MODE_WRITE = 2'd0,
      MODE_ADVECT = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_INTERP = 2'd0,
      ST_HELD = 2'd1,
      ST_NOT_FLUID = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_FLUID = 2'd0
   } kind_type;

   localparam logic [1:0] CSR_STEP = 2'd0;
   localparam logic [1:0] CSR_BACK = 2'd1;
   localparam logic [1:0] CSR_WRAP = 2'd2;
   localparam logic [1:0] CSR_TRACK = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE, S_TGT, S_MUL, S_POS, S_RD0, S_RD1, S_RD2, S_RD3, S_LAST, S_C0, S_C1,
      S_MIX, S_OUT
   } state_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [10:0] i, input logic [10:0] j);
      logic [ADDR_W+11:0] a;
      a = (ADDR_W+12)'(j) * (ADDR_W+12)'(PAD_W) + (ADDR_W+12)'(i);
      return a[ADDR_W-1:0];
   endfunction
endpackage

// ===== design/sla_grid_mem.sv =====
// grid memory holding value and kind per padded cell
// depends on sla_pkg
module sla_grid_mem import sla_pkg::*; (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [ADDR_W-1:0]       wr_addr,
   input  logic signed [VAL_W-1:0] wr_value,
   input  logic [1:0]              wr_kind,
   input  logic [ADDR_W-1:0]       rd_addr,
   output logic signed [VAL_W-1:0] rd_value,
   output logic [1:0]              rd_kind
);
   logic [VAL_W+1:0] mem [STORE_N];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_kind, wr_value};
      end
      {rd_kind, rd_value} <= mem[rd_addr];
   end
endmodule

// ===== design/semi_lagrangian_grid_advect.sv =====
// advect item: reads the target, multiplies, traces the position, reads four corners and
// mixes two columns; held at the target value when three or more corners are not fluid,
// not interpolated when the target is not fluid; one item at a time, the next item is
// accepted in the cycle after the result leaves; the corner and target reads share the
// single grid memory read port; write and clear items give no result and can follow back
// to back; reset is synchronous: control, configuration and running maximum take reset
// values; the grid memory is not cleared and reads as undefined until written
`include "semi_lagrangian_grid_advect_assert.svh"
module semi_lagrangian_grid_advect import sla_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode, cell_x, cell_y, cell_value, cell_kind, vel_x, vel_y (pad to 88 bits)
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // advected_value, running_max (48 bits)
   output logic [47:0] rsp_tdata,
   // result_status
   output logic [1:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   state_type state_ff, state_in;
   logic [23:0] step_ff;
   logic back_ff, wrap_ff, track_ff;
   logic signed [VAL_W-1:0] max_ff, max_in;

   logic [5:0] cx_ff, cy_ff;
   logic signed [23:0] vx_ff, vy_ff;
   logic signed [VAL_W-1:0] tval_ff;
   logic signed [48:0] mx_ff, my_ff;
   logic [10:0] i0_ff, j0_ff;
   logic [FRAC_BITS-1:0] s1_ff, t1_ff;
   logic signed [VAL_W-1:0] v_ff [4];
   logic [2:0] nf_ff;
   logic signed [VAL_W-1:0] c0_ff, c1_ff;
   logic [1:0] stat_ff;
   logic out_v_ff;

   mode_type req_mode;
   logic [5:0] req_x, req_y;
   logic signed [23:0] req_val, req_vx, req_vy;
   logic [1:0] req_kind;
   logic acc, inside_req;
   assign req_mode = mode_type'(req_tdata[1:0]);
   assign req_x = req_tdata[7:2];
   assign req_y = req_tdata[13:8];
   assign req_val = req_tdata[37:14];
   assign req_kind = req_tdata[39:38];
   assign req_vx = req_tdata[63:40];
   assign req_vy = req_tdata[87:64];
   assign req_tready = (state_ff == S_IDLE) && !out_v_ff;
   assign acc = req_tvalid && req_tready;
   assign inside_req = (32'(req_x) < PAD_W) && (32'(req_y) < PAD_H);

   logic [ADDR_W-1:0] rd_addr;
   logic signed [VAL_W-1:0] rd_value;
   logic [1:0] rd_kind;

   sla_grid_mem u_mem (
      .clock(clock), .wr_en(acc && req_mode == MODE_WRITE && inside_req),
      .wr_addr(cell_addr(11'(req_x), 11'(req_y))), .wr_value(req_val), .wr_kind(req_kind),
      .rd_addr(rd_addr), .rd_value(rd_value), .rd_kind(rd_kind)
   );

   always_comb begin
      unique case (state_ff)
         S_RD0: rd_addr = cell_addr(i0_ff, j0_ff);
         S_RD1: rd_addr = cell_addr(i0_ff, j0_ff + 11'd1);
         S_RD2: rd_addr = cell_addr(i0_ff + 11'd1, j0_ff);
         S_RD3: rd_addr = cell_addr(i0_ff + 11'd1, j0_ff + 11'd1);
         default: rd_addr = cell_addr(11'(cx_ff), 11'(cy_ff));
      endcase
   end

   // position arithmetic
   localparam logic signed [POS_W-1:0] ONE = POS_W'(1) <<< FRAC_BITS;
   localparam logic signed [POS_W-1:0] HALF = POS_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [POS_W-1:0] XW = POS_W'(GRID_W) * ONE;
   localparam logic signed [POS_W-1:0] XW1 = POS_W'(GRID_W + 1) * ONE;
   localparam logic signed [POS_W-1:0] XHI = XW + HALF;
   localparam logic signed [POS_W-1:0] YHI = POS_W'(GRID_H) * ONE + HALF;
   logic signed [POS_W-1:0] dx, dy, px, py, px1, py1;
   always_comb begin
      dx = POS_W'(mx_ff >>> FRAC_BITS);
      dy = POS_W'(my_ff >>> FRAC_BITS);
      px = POS_W'(cx_ff) <<< FRAC_BITS;
      py = POS_W'(cy_ff) <<< FRAC_BITS;
      if (back_ff) begin
         px = px - dx;
         py = py - dy;
      end else begin
         px = px + dx;
         py = py + dy;
      end
      px1 = px;
      if (wrap_ff) begin
         if (px <= 0) px1 = px + XW;
         else if (px >= XW1) px1 = px - XW;
         if (px1 < 0) px1 = '0;
         if (px1 > XW1 - 1) px1 = XW1 - 1;
      end else begin
         if (px < HALF) px1 = HALF;
         else if (px > XHI) px1 = XHI;
      end
      py1 = py;
      if (py < HALF) py1 = HALF;
      else if (py > YHI) py1 = YHI;
   end

   // interpolation arithmetic
   logic signed [FRAC_BITS+1:0] s1s, s0s, t1s, t0s;
   logic signed [63:0] colsum, mixsum, rnd;
   localparam logic signed [63:0] RHALF = 64'sd1 <<< (FRAC_BITS - 1);
   assign s1s = (FRAC_BITS+2)'(s1_ff);
   assign t1s = (FRAC_BITS+2)'(t1_ff);
   assign s0s = (FRAC_BITS+2)'(1) <<< FRAC_BITS;
   assign t0s = ((FRAC_BITS+2)'(1) <<< FRAC_BITS) - t1s;
   always_comb begin
      if (state_ff == S_C0)
         colsum = 64'(t0s * v_ff[0]) + 64'(t1s * v_ff[1]);
      else
         colsum = 64'(t0s * v_ff[2]) + 64'(t1s * v_ff[3]);
      mixsum = 64'((s0s - s1s) * c0_ff) + 64'(s1s * c1_ff);
      rnd = (mixsum + RHALF) >>> FRAC_BITS;
   end
   logic signed [63:0] colr;
   assign colr = (colsum + RHALF) >>> FRAC_BITS;
   logic signed [VAL_W-1:0] satv;
   always_comb begin
      if (rnd > 64'sd8388607) satv = 24'sh7FFFFF;
      else if (rnd < -64'sd8388608) satv = 24'sh800000;
      else satv = rnd[VAL_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (acc && req_mode == MODE_ADVECT) state_in = S_TGT;
         S_TGT: state_in = S_MUL;
         S_MUL: state_in = S_POS;
         S_POS: state_in = S_RD0;
         S_RD0: state_in = S_RD1;
         S_RD1: state_in = S_RD2;
         S_RD2: state_in = S_RD3;
         S_RD3: state_in = S_LAST;
         S_LAST: state_in = S_C0;
         S_C0: state_in = S_C1;
         S_C1: state_in = S_MIX;
         S_MIX: state_in = S_OUT;
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_MUL && (!(32'(cx_ff) < PAD_W && 32'(cy_ff) < PAD_H)
                               || rd_kind != KIND_FLUID))
         state_in = S_OUT;
      if (state_ff == S_LAST && (nf_ff + 3'(rd_kind != KIND_FLUID)) >= 3'd3)
         state_in = S_OUT;
   end

   always_comb begin
      max_in = max_ff;
      if (acc && req_mode == MODE_CLEAR) max_in = '0;
      else if (state_ff == S_MIX && track_ff && satv != 0 && satv > max_ff) max_in = satv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= 24'd65536;
         back_ff <= 1'b1;
         wrap_ff <= 1'b0;
         track_ff <= 1'b0;
         max_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         max_ff <= max_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_STEP: step_ff <= csr_wdata;
               CSR_BACK: back_ff <= csr_wdata[0];
               CSR_WRAP: wrap_ff <= csr_wdata[0];
               CSR_TRACK: track_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (state_ff == S_OUT) out_v_ff <= 1'b1;
         else if (rsp_tready) out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         cx_ff <= req_x;
         cy_ff <= req_y;
         vx_ff <= req_vx;
         vy_ff <= req_vy;
      end
      unique case (state_ff)
         S_TGT: begin
            mx_ff <= $signed({1'b0, step_ff}) * vx_ff;
            my_ff <= $signed({1'b0, step_ff}) * vy_ff;
         end
         S_MUL: begin
            tval_ff <= (32'(cx_ff) < PAD_W && 32'(cy_ff) < PAD_H) ? rd_value : '0;
            stat_ff <= ST_NOT_FLUID;
         end
         S_POS: begin
            i0_ff <= 11'(px1 >>> FRAC_BITS);
            j0_ff <= 11'(py1 >>> FRAC_BITS);
            s1_ff <= px1[FRAC_BITS-1:0];
            t1_ff <= py1[FRAC_BITS-1:0];
            nf_ff <= '0;
         end
         S_RD1, S_RD2, S_RD3: nf_ff <= nf_ff + 3'(rd_kind != KIND_FLUID);
         S_LAST: stat_ff <= ST_HELD;
         S_C0: c0_ff <= VAL_W'(colr);
         S_C1: c1_ff <= VAL_W'(colr);
         S_MIX: begin
            tval_ff <= satv;
            stat_ff <= ST_INTERP;
         end
         default: ;
      endcase
      if (state_ff == S_RD1) v_ff[0] <= rd_value;
      if (state_ff == S_RD2) v_ff[1] <= rd_value;
      if (state_ff == S_RD3) v_ff[2] <= rd_value;
      if (state_ff == S_LAST) v_ff[3] <= rd_value;
      if (state_ff == S_OUT) begin
         rsp_tuser <= stat_ff;
         rsp_tdata <= {max_ff, tval_ff};
      end
   end

   assign rsp_tvalid = out_v_ff;

   `SLA_ASSERT_IMPL(a_busy_no_accept, clock, reset, state_ff != S_IDLE, !req_tready, "busy accepted")
   `SLA_ASSERT_NEXT(a_out_sets_valid, clock, reset, state_ff == S_OUT, rsp_tvalid, "no result")
   `SLA_ASSERT_IMPL(a_valid_idle, clock, reset, rsp_tvalid, state_ff == S_IDLE, "result overlaps work")
endmodule

// ===== verif/semi_lagrangian_grid_advect_checker.sv =====
`timescale 1ns / 1ps
// checker for the grid advection block: watches the request, response and csr ports,
// predicts each advect result from its own grid copy and compares it; depends on sla_pkg
module semi_lagrangian_grid_advect_checker import sla_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [87:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata,
   output int          failures,
   output int          pending
);
   typedef struct packed {
      logic signed [23:0] value;
      status_type         status;
      logic signed [23:0] peak;
   } advect_result_type;

   logic [23:0]        step_scale;
   logic               backward, wrap_x, track_max;
   logic signed [23:0] peak_reg;
   logic signed [23:0] grid_value [STORE_N];
   logic [1:0]         grid_kind [STORE_N];
   advect_result_type  awaited [$];

   function automatic int cell_index(input longint i, input longint j);
      return int'(j * PAD_W + i);
   endfunction

   function automatic advect_result_type advect_cell(input logic [5:0] cx, input logic [5:0] cy,
                                                     input logic signed [23:0] vx,
                                                     input logic signed [23:0] vy);
      longint one, half, dx, dy, px, py, i0, j0, s1, t1, c0, c1, r;
      int nonfluid;
      advect_result_type res;
      one = longint'(1) << FRAC_BITS;
      half = one >> 1;
      res.value = grid_value[cell_index(cx, cy)];
      res.status = ST_NOT_FLUID;
      if (grid_kind[cell_index(cx, cy)] == KIND_FLUID) begin
         dx = (longint'({40'b0, step_scale}) * longint'(vx)) >>> FRAC_BITS;
         dy = (longint'({40'b0, step_scale}) * longint'(vy)) >>> FRAC_BITS;
         px = longint'(cx) * one;
         py = longint'(cy) * one;
         if (backward) begin
            px = px - dx;
            py = py - dy;
         end else begin
            px = px + dx;
            py = py + dy;
         end
         if (wrap_x) begin
            if (px <= 0) px = px + GRID_W * one;
            else if (px >= (GRID_W + 1) * one) px = px - GRID_W * one;
            if (px < 0) px = 0;
            if (px > (GRID_W + 1) * one - 1) px = (GRID_W + 1) * one - 1;
         end else begin
            if (px < half) px = half;
            else if (px > GRID_W * one + half) px = GRID_W * one + half;
         end
         if (py < half) py = half;
         else if (py > GRID_H * one + half) py = GRID_H * one + half;
         i0 = px >>> FRAC_BITS;
         j0 = py >>> FRAC_BITS;
         s1 = px & (one - 1);
         t1 = py & (one - 1);
         nonfluid = 0;
         if (grid_kind[cell_index(i0, j0)] != KIND_FLUID) nonfluid++;
         if (grid_kind[cell_index(i0, j0 + 1)] != KIND_FLUID) nonfluid++;
         if (grid_kind[cell_index(i0 + 1, j0)] != KIND_FLUID) nonfluid++;
         if (grid_kind[cell_index(i0 + 1, j0 + 1)] != KIND_FLUID) nonfluid++;
         if (nonfluid >= 3) begin
            res.status = ST_HELD;
         end else begin
            c0 = ((one - t1) * longint'(grid_value[cell_index(i0, j0)])
                  + t1 * longint'(grid_value[cell_index(i0, j0 + 1)]) + half) >>> FRAC_BITS;
            c1 = ((one - t1) * longint'(grid_value[cell_index(i0 + 1, j0)])
                  + t1 * longint'(grid_value[cell_index(i0 + 1, j0 + 1)]) + half) >>> FRAC_BITS;
            r = ((one - s1) * c0 + s1 * c1 + half) >>> FRAC_BITS;
            if (r > 8388607) r = 8388607;
            if (r < -8388608) r = -8388608;
            res.value = r[23:0];
            res.status = ST_INTERP;
            if (track_max && r != 0 && r > longint'(peak_reg)) peak_reg = r[23:0];
         end
      end
      res.peak = peak_reg;
      return res;
   endfunction

   always @(posedge clock) begin
      advect_result_type want;
      mode_type mode;
      if (reset) begin
         step_scale <= 24'd65536;
         backward <= 1'b1;
         wrap_x <= 1'b0;
         track_max <= 1'b0;
         peak_reg = '0;
         failures <= 0;
         pending <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_STEP:  step_scale <= csr_wdata;
               CSR_BACK:  backward <= csr_wdata[0];
               CSR_WRAP:  wrap_x <= csr_wdata[0];
               CSR_TRACK: track_max <= csr_wdata[0];
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (awaited.size() == 0) begin
               failures <= failures + 1;
               if (failures < 10) $display("unexpected transaction: %h %h", rsp_tdata, rsp_tuser);
            end else begin
               want = awaited.pop_front();
               if (rsp_tdata[23:0] !== want.value || rsp_tuser !== want.status ||
                   rsp_tdata[47:24] !== want.peak) begin
                  failures <= failures + 1;
                  if (failures < 10)
                     $display("mismatch: expected value %h status %0d max %h, got %h %0d %h",
                              want.value, want.status, want.peak,
                              rsp_tdata[23:0], rsp_tuser, rsp_tdata[47:24]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            mode = mode_type'(req_tdata[1:0]);
            case (mode)
               MODE_WRITE: begin
                  grid_value[cell_index(req_tdata[7:2], req_tdata[13:8])] = req_tdata[37:14];
                  grid_kind[cell_index(req_tdata[7:2], req_tdata[13:8])] = req_tdata[39:38];
               end
               MODE_ADVECT: awaited.insert(awaited.size(),
                                           advect_cell(req_tdata[7:2], req_tdata[13:8],
                                                       req_tdata[63:40], req_tdata[87:64]));
               MODE_CLEAR: peak_reg = '0;
               default: ;
            endcase
         end
         pending <= awaited.size();
      end
   end
endmodule

// ===== verif/tb_semi_lagrangian_grid_advect.sv =====
`timescale 1ns / 1ps
// top of the grid advection testbench: clock, reset, stimulus and verdict
// depends on sla_pkg, semi_lagrangian_grid_advect and semi_lagrangian_grid_advect_checker
module tb_semi_lagrangian_grid_advect import sla_pkg::*;;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_STEP;
   logic [23:0] csr_wdata = '0;
   int          failures, pending;
   int          cycles = 0;
   int          stall = 0;
   logic        quiet = 1'b0;
   logic [23:0] cur_step = 24'd65536;
   logic        cur_back = 1'b1;

   semi_lagrangian_grid_advect dut (.*);
   semi_lagrangian_grid_advect_checker checker_i (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 1500000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall > 0) begin
         stall <= stall - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall <= $urandom_range(0, 16);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send(input mode_type mode, input logic [5:0] x, input logic [5:0] y,
                       input logic [23:0] val, input logic [1:0] kind,
                       input logic [23:0] vx, input logic [23:0] vy);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {vy, vx, kind, val, y, x, mode};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic configure(input logic [23:0] step, input logic back, input logic wrap,
                            input logic track);
      req_tvalid <= 1'b0;
      cur_step = step;
      cur_back = back;
      csr_we <= 1'b1;
      csr_index <= CSR_STEP;
      csr_wdata <= step;
      @(posedge clock);
      csr_index <= CSR_BACK;
      csr_wdata <= {23'b0, back};
      @(posedge clock);
      csr_index <= CSR_WRAP;
      csr_wdata <= {23'b0, wrap};
      @(posedge clock);
      csr_index <= CSR_TRACK;
      csr_wdata <= {23'b0, track};
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [23:0] pick_velocity();
      if ($urandom_range(0, 9) < 6) return 24'($urandom_range(0, 6 * 65536)) - 24'(3 * 65536);
      return 24'($urandom);
   endfunction

   function automatic logic [1:0] pick_kind();
      return ($urandom_range(0, 9) < 8) ? 2'd0 : 2'($urandom_range(1, 3));
   endfunction

   // only rows 0 to 3 and 60 to 63 are loaded
   function automatic logic [5:0] pick_band_row();
      int r;
      r = $urandom_range(0, 7);
      return (r < 4) ? 6'(r) : 6'(56 + r);
   endfunction

   function automatic logic [5:0] pick_target_row();
      int r;
      r = $urandom_range(0, 6);
      return (r < 3) ? 6'(r) : 6'(57 + r);
   endfunction

   // true when every corner row of the traced point lies in a loaded band
   function automatic logic row_ok(input logic [5:0] cy, input logic [23:0] vy);
      longint one, dy, py;
      one = longint'(1) << FRAC_BITS;
      dy = (longint'(cur_step) * longint'($signed(vy))) >>> FRAC_BITS;
      py = cur_back ? longint'(cy) * one - dy : longint'(cy) * one + dy;
      if (py < (one >> 1)) py = one >> 1;
      if (py > GRID_H * one + (one >> 1)) py = GRID_H * one + (one >> 1);
      return ((py >>> FRAC_BITS) <= 2) || ((py >>> FRAC_BITS) >= 60);
   endfunction

   function automatic logic [23:0] pick_vy(input logic [5:0] cy);
      logic [23:0] vy;
      for (int k = 0; k < 8; k++) begin
         vy = pick_velocity();
         if (row_ok(cy, vy)) return vy;
      end
      return '0;
   endfunction

   task automatic random_items(input int count);
      int roll;
      logic [5:0] row;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 15)
            send(MODE_WRITE, 6'($urandom), pick_band_row(), 24'($urandom), pick_kind(),
                 24'($urandom), 24'($urandom));
         else if (roll < 20)
            send(MODE_CLEAR, 6'($urandom), 6'($urandom), 24'($urandom), 2'($urandom), 24'($urandom),
                 24'($urandom));
         else if (roll < 22)
            send(MODE_NONE, 6'($urandom), 6'($urandom), 24'($urandom), 2'($urandom), 24'($urandom),
                 24'($urandom));
         else begin
            row = pick_target_row();
            send(MODE_ADVECT, 6'($urandom), row, 24'($urandom), 2'($urandom),
                 pick_velocity(), pick_vy(row));
         end
      end
   endtask

   initial begin
      logic [23:0] steps [6];
      logic [2:0]  flags [6];
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // load the bottom and top bands; every advect reads only inside them
      for (int y = 0; y < PAD_H; y++)
         if (y < 4 || y >= PAD_H - 4)
            for (int x = 0; x < PAD_W; x++)
               send(MODE_WRITE, 6'(x), 6'(y), 24'($urandom), pick_kind(), '0, '0);
      // directed: extremes, held corners, non-fluid target, wrap, clear, ignored mode
      send(MODE_WRITE, 6'd20, 6'd1, 24'h7fffff, 2'd0, '0, '0);
      send(MODE_WRITE, 6'd20, 6'd2, 24'h000100, 2'd1, '0, '0);
      send(MODE_WRITE, 6'd21, 6'd1, 24'h800000, 2'd2, '0, '0);
      send(MODE_WRITE, 6'd21, 6'd2, 24'h000000, 2'd3, '0, '0);
      send(MODE_ADVECT, 6'd20, 6'd1, '0, '0, '0, '0);
      send(MODE_WRITE, 6'd30, 6'd61, 24'h123456, 2'd1, '0, '0);
      send(MODE_ADVECT, 6'd30, 6'd61, '0, '0, 24'h010000, 24'h010000);
      send(MODE_WRITE, 6'd1, 6'd62, 24'h010000, 2'd0, '0, '0);
      send(MODE_WRITE, 6'd40, 6'd61, 24'h7fffff, 2'd0, '0, '0);
      send(MODE_WRITE, 6'd41, 6'd61, 24'h7fffff, 2'd0, '0, '0);
      send(MODE_WRITE, 6'd40, 6'd62, 24'h7fffff, 2'd0, '0, '0);
      send(MODE_WRITE, 6'd41, 6'd62, 24'h7fffff, 2'd0, '0, '0);
      configure(24'd65536, 1'b1, 1'b1, 1'b1);
      send(MODE_ADVECT, 6'd1, 6'd62, '0, '0, 24'h018000, 24'h000000);
      send(MODE_ADVECT, 6'd62, 6'd62, '0, '0, 24'hfe8000, 24'h000000);
      send(MODE_ADVECT, 6'd40, 6'd61, '0, '0, 24'hff8000, 24'hff8000);
      send(MODE_ADVECT, 6'd10, 6'd1, '0, '0, 24'h7fffff, 24'h800000);
      send(MODE_ADVECT, 6'd10, 6'd1, '0, '0, 24'h800000, 24'h7fffff);
      send(MODE_ADVECT, 6'd63, 6'd63, '0, '0, 24'h000000, 24'h000000);
      send(MODE_CLEAR, '0, '0, '0, '0, '0, '0);
      send(MODE_NONE, 6'd63, 6'd63, 24'hffffff, 2'd3, 24'hffffff, 24'hffffff);
      send(MODE_ADVECT, 6'd0, 6'd0, '0, '0, 24'h7fffff, 24'h7fffff);
      settle();
      steps = '{24'd65536, 24'hffffff, 24'd0, 24'($urandom), 24'd32768, 24'd131072};
      flags = '{3'b101, 3'b010, 3'b101, 3'b011, 3'b001, 3'b111};
      for (int p = 0; p < 6; p++) begin
         if (p == 5) quiet = 1'b1;
         configure(steps[p], flags[p][2], flags[p][1], flags[p][0]);
         random_items(70);
         settle();
      end
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
